// ===== design/bit_vector_store_unit_defines.svh =====
// Assertion macros shared by the bit vector store RTL.
// Needs a clock named clk and an active-low reset named arst_n in the using module.
`ifndef BIT_VECTOR_STORE_UNIT_DEFINES_SVH
`define BIT_VECTOR_STORE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define BVS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that pre in one cycle is followed by post in the next.
`define BVS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define BVS_ASSERT(lbl, prop, msg)
`define BVS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== design/bvs_pkg.sv =====
// Types and constants of the bit vector store.
// No dependencies; used by bvs_ctrl, bvs_dp and bit_vector_store_unit.
package bvs_pkg;

	localparam int MAX_BITS  = 1024;
	localparam int WORD_BITS = 64;
	localparam int CFG_W     = 11;
	localparam int OP_W      = 4;
	localparam int BITPOS_W  = 6;   // bit position inside one word
	localparam int WCNT_W    = 6;   // words in use, up to 16 once the length is clamped to 1024

	typedef logic [WORD_BITS-1:0] word_t;

	localparam logic [CFG_W-1:0] BITS_RESET = 11'd1024;

	localparam logic [OP_W-1:0] OP_SET      = 4'd0;
	localparam logic [OP_W-1:0] OP_CLR      = 4'd1;
	localparam logic [OP_W-1:0] OP_FLIP     = 4'd2;
	localparam logic [OP_W-1:0] OP_TEST     = 4'd3;
	localparam logic [OP_W-1:0] OP_SET_ALL  = 4'd4;
	localparam logic [OP_W-1:0] OP_CLR_ALL  = 4'd5;
	localparam logic [OP_W-1:0] OP_FLIP_ALL = 4'd6;
	localparam logic [OP_W-1:0] OP_AND      = 4'd7;
	localparam logic [OP_W-1:0] OP_OR       = 4'd8;
	localparam logic [OP_W-1:0] OP_XOR      = 4'd9;
	localparam logic [OP_W-1:0] OP_CMP      = 4'd10;

	// controller to datapath
	typedef struct packed {
		logic cfg_load;   // take new length, zero count, restart clearing pass
		logic accept;     // latch request, issue word read
		logic clr_step;   // write zero at clearing pointer, advance
		logic exec;       // modify the word read, write back
		logic count;      // fold popcount difference into the count
		logic bulk_step;  // one step of an all-bits walk
		logic bulk_last;  // walk finished, set count
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_bulk;    // request on the input ports is an all-bits operation
		logic need_count; // word operation that needs a popcount stage
		logic bulk_done;  // walk pointer reached the words in use
		logic clr_done;   // clearing pointer at the last word
	} sts_t;

endpackage

// ===== design/bit_vector_store_unit.sv =====
// Bit vector store of up to 1024 bits in 64-bit words with a running set count.
// Single-bit ops, compare and rejected requests: accept, exec, then the result register;
// AND/OR/XOR add a popcount stage after exec; all-bits ops walk the words in use
// (one RAM word a cycle). The next request can be taken in the cycle the result strobe shows.
// Reset and every length write start a clearing pass, busy meanwhile. The receiver
// cannot stall: each result is valid for exactly one cycle. Uses bvs_pkg, bvs_ctrl, bvs_dp.
module bit_vector_store_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        start,
	output logic                        busy,
	input  logic [bvs_pkg::OP_W-1:0]    opcode,
	input  logic [9:0]                  bit_pos,
	input  logic [3:0]                  word_sel,
	input  bvs_pkg::word_t              source_word,
	// length register write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bvs_pkg::CFG_W-1:0]   bits_in_use,
	// result channel
	output logic                        result_valid,
	output logic                        status,
	output logic                        bit_value,
	output logic                        words_equal,
	output logic [bvs_pkg::CFG_W-1:0]   set_count,
	output logic                        all_set,
	output logic                        any_set,
	output logic                        none_set
);
	bvs_pkg::cmd_t cmd;
	bvs_pkg::sts_t sts;

	// The length register takes a write in any cycle. A write zeroes the count at once and
	// restarts the clearing pass over the whole word RAM; requests are held off until it ends.
	assign cfg_ready = 1'b1;

	// Controller: clearing pass, request accept, one-word read-modify-write (exec),
	// optional popcount stage for word logic ops, and the all-bits walk.
	bvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	// Datapath: word RAM with registered read, count and flags, result registers.
	// Single-bit ops adjust the count by at most one; AND/OR/XOR take the popcount difference
	// of the old and new word in the count stage after exec; all-bits ops set the count directly
	// (length, zero, or length minus count) while the walk rewrites each word in use.
	bvs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.bit_pos      (bit_pos),
		.word_sel     (word_sel),
		.source_word  (source_word),
		.cfg_data     (bits_in_use),
		.result_valid (result_valid),
		.status       (status),
		.bit_value    (bit_value),
		.words_equal  (words_equal),
		.set_count    (set_count),
		.all_set      (all_set),
		.any_set      (any_set),
		.none_set     (none_set)
	);

endmodule

// ===== design/bvs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bvs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/bvs_ctrl.sv =====
// Controller state machine of the bit vector store.
// Depends on bvs_pkg and bit_vector_store_unit_defines.svh.
`include "bit_vector_store_unit_defines.svh"

module bvs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          cfg_valid,
	input  bvs_pkg::sts_t sts,
	output bvs_pkg::cmd_t cmd,
	output logic          busy
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_COUNT = 3'd3;
	localparam logic [2:0] S_BULK  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [4:0] act_vec;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		if (cfg_valid) begin
			cmd.cfg_load = 1'b1;
			state_d      = S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					cmd.clr_step = 1'b1;
					if (sts.clr_done) begin
						state_d = S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd.accept = 1'b1;
						state_d    = sts.in_bulk ? S_BULK : S_EXEC;
					end
				end
				S_EXEC: begin
					cmd.exec = 1'b1;
					state_d  = sts.need_count ? S_COUNT : S_IDLE;
				end
				S_COUNT: begin
					cmd.count = 1'b1;
					state_d   = S_IDLE;
				end
				S_BULK: begin
					cmd.bulk_step = 1'b1;
					if (sts.bulk_done) begin
						cmd.bulk_last = 1'b1;
						state_d       = S_IDLE;
					end
				end
				default: begin
					state_d = S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// hold off requests while working and while a length write restarts the clear
	assign busy = (state_q != S_IDLE) || cfg_valid;

	assign act_vec = {cmd.accept, cmd.clr_step, cmd.exec, cmd.count, cmd.bulk_step};

	`BVS_ASSERT(a_one_action, $onehot0(act_vec), "more than one datapath action")
	`BVS_ASSERT_NEXT(a_exec_exit, state_q == S_EXEC, state_q == S_IDLE || state_q == S_COUNT || state_q == S_CLEAR, "bad exit from exec")
	`BVS_ASSERT_NEXT(a_accept_next, cmd.accept, state_q == S_EXEC || state_q == S_BULK, "accepted request not started")

endmodule

// ===== design/bvs_dp.sv =====
// Datapath of the bit vector store: word RAM, count, length register, result registers.
// Depends on bvs_pkg, bvs_ram and bit_vector_store_unit_defines.svh.
`include "bit_vector_store_unit_defines.svh"

module bvs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bvs_pkg::cmd_t                 cmd,
	output bvs_pkg::sts_t                 sts,
	input  logic [bvs_pkg::OP_W-1:0]      opcode,
	input  logic [9:0]                    bit_pos,
	input  logic [3:0]                    word_sel,
	input  bvs_pkg::word_t                source_word,
	input  logic [bvs_pkg::CFG_W-1:0]     cfg_data,
	output logic                          result_valid,
	output logic                          status,
	output logic                          bit_value,
	output logic                          words_equal,
	output logic [bvs_pkg::CFG_W-1:0]     set_count,
	output logic                          all_set,
	output logic                          any_set,
	output logic                          none_set
);
	localparam int STORE_WORDS =
		(bvs_pkg::MAX_BITS + bvs_pkg::WORD_BITS - 1) / bvs_pkg::WORD_BITS;
	localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	// valid bits of word w under length nb
	function automatic bvs_pkg::word_t word_mask(input logic [10:0] nb, input logic [5:0] w);
		logic [11:0] base;
		logic [11:0] valid;
		base  = {w, 6'd0};
		valid = {1'b0, nb} - base;
		if (base >= {1'b0, nb}) begin
			word_mask = '0;
		end else if (valid >= 12'd64) begin
			word_mask = '1;
		end else begin
			word_mask = (bvs_pkg::word_t'(1) << valid[5:0]) - bvs_pkg::word_t'(1);
		end
	endfunction

	function automatic logic [6:0] pop64(input bvs_pkg::word_t v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < bvs_pkg::WORD_BITS; i++) begin
			n = n + 7'(v[i]);
		end
		return n;
	endfunction

	logic [bvs_pkg::CFG_W-1:0]    cfg_bits_q;
	logic [bvs_pkg::CFG_W-1:0]    count_q;
	logic [bvs_pkg::CFG_W-1:0]    count_d;
	logic [AW-1:0]                clr_ptr_q;
	logic [bvs_pkg::OP_W-1:0]     op_q;
	logic [bvs_pkg::BITPOS_W-1:0] bit_q;
	logic [3:0]                   widx_q;
	bvs_pkg::word_t               src_q;
	logic                         err_q;
	logic [bvs_pkg::WCNT_W-1:0]   ptr_q;
	logic                         bwr_v_q;
	logic [bvs_pkg::WCNT_W-1:0]   bwr_w_q;
	bvs_pkg::word_t               old_s1;
	bvs_pkg::word_t               new_s1;
	logic                         result_valid_q;
	logic                         status_q;
	logic                         bit_value_q;
	logic                         words_equal_q;

	logic [bvs_pkg::CFG_W-1:0]    nbits;
	logic [bvs_pkg::WCNT_W-1:0]   nwords;
	logic                         in_bit_op;
	logic                         in_bulk;
	logic                         in_err;
	logic [3:0]                   acc_widx;
	logic                         op_bit;
	logic                         op_logic;
	logic                         writes_word;
	bvs_pkg::word_t               old_word;
	bvs_pkg::word_t               new_word;
	bvs_pkg::word_t               bmask;
	bvs_pkg::word_t               wmask;
	bvs_pkg::word_t               bulk_word;
	logic                         old_bit;
	logic                         ex_bitv;
	logic                         ex_eq;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	bvs_pkg::word_t               ram_wdata;
	logic [AW-1:0]                ram_raddr;
	bvs_pkg::word_t               ram_rdata;

	// effective length: zero acts as one, clamp to capacity
	always_comb begin
		if (cfg_bits_q == '0) begin
			nbits = 11'd1;
		end else if (32'(cfg_bits_q) > bvs_pkg::MAX_BITS) begin
			nbits = 11'(bvs_pkg::MAX_BITS);
		end else begin
			nbits = cfg_bits_q;
		end
	end

	assign nwords = 6'(({1'b0, nbits} + 12'd63) >> 6);

	// decode of the request on the ports
	assign in_bit_op = (opcode <= bvs_pkg::OP_TEST);
	assign in_bulk   = (opcode == bvs_pkg::OP_SET_ALL) || (opcode == bvs_pkg::OP_CLR_ALL) ||
	                   (opcode == bvs_pkg::OP_FLIP_ALL);
	assign acc_widx  = in_bit_op ? bit_pos[9:6] : word_sel;

	always_comb begin
		if (in_bit_op) begin
			in_err = ({1'b0, bit_pos} >= nbits);
		end else if (in_bulk) begin
			in_err = 1'b0;
		end else if (opcode <= bvs_pkg::OP_CMP) begin
			in_err = ({2'b00, word_sel} >= nwords);
		end else begin
			in_err = 1'b1;
		end
	end

	// read-modify-write of one word
	assign old_word = ram_rdata;
	assign bmask    = bvs_pkg::word_t'(1) << bit_q;
	assign wmask    = word_mask(nbits, {2'b00, widx_q});
	assign old_bit  = |(old_word & bmask);
	assign op_bit   = (op_q == bvs_pkg::OP_SET) || (op_q == bvs_pkg::OP_CLR) ||
	                  (op_q == bvs_pkg::OP_FLIP);
	assign op_logic = (op_q == bvs_pkg::OP_AND) || (op_q == bvs_pkg::OP_OR) ||
	                  (op_q == bvs_pkg::OP_XOR);
	assign writes_word = !err_q && (op_bit || op_logic);

	always_comb begin
		case (op_q)
			bvs_pkg::OP_SET:  new_word = old_word | bmask;
			bvs_pkg::OP_CLR:  new_word = old_word & ~bmask;
			bvs_pkg::OP_FLIP: new_word = old_word ^ bmask;
			bvs_pkg::OP_AND:  new_word = old_word & src_q & wmask;
			bvs_pkg::OP_OR:   new_word = (old_word | src_q) & wmask;
			bvs_pkg::OP_XOR:  new_word = (old_word ^ src_q) & wmask;
			default:          new_word = old_word;
		endcase
	end

	assign ex_bitv = !err_q && (op_q == bvs_pkg::OP_TEST) && old_bit;
	assign ex_eq   = !err_q && (op_q == bvs_pkg::OP_CMP) && (((old_word ^ src_q) & wmask) == '0);

	// all-bits walk: the word read one step ago is written back now
	always_comb begin
		case (op_q)
			bvs_pkg::OP_SET_ALL: bulk_word = word_mask(nbits, bwr_w_q);
			bvs_pkg::OP_CLR_ALL: bulk_word = '0;
			default:             bulk_word = ~ram_rdata & word_mask(nbits, bwr_w_q);
		endcase
	end

	// RAM port selection
	assign ram_raddr = cmd.accept ? AW'(acc_widx) : AW'(ptr_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_ptr_q;
		ram_wdata = '0;
		if (cmd.clr_step) begin
			ram_we = 1'b1;
		end else if (cmd.exec && writes_word) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(widx_q);
			ram_wdata = new_word;
		end else if (cmd.bulk_step && bwr_v_q) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(bwr_w_q);
			ram_wdata = bulk_word;
		end
	end

	bvs_ram #(
		.WIDTH (bvs_pkg::WORD_BITS),
		.DEPTH (STORE_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// count update
	always_comb begin
		count_d = count_q;
		if (cmd.cfg_load) begin
			count_d = '0;
		end else if (cmd.exec && !err_q && op_bit) begin
			if (op_q == bvs_pkg::OP_SET) begin
				count_d = old_bit ? count_q : count_q + 11'd1;
			end else if (op_q == bvs_pkg::OP_CLR) begin
				count_d = old_bit ? count_q - 11'd1 : count_q;
			end else begin
				count_d = old_bit ? count_q - 11'd1 : count_q + 11'd1;
			end
		end else if (cmd.count) begin
			count_d = count_q - 11'(pop64(old_s1)) + 11'(pop64(new_s1));
		end else if (cmd.bulk_last) begin
			case (op_q)
				bvs_pkg::OP_SET_ALL: count_d = nbits;
				bvs_pkg::OP_CLR_ALL: count_d = '0;
				default:             count_d = nbits - count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bits_q     <= bvs_pkg::BITS_RESET;
			count_q        <= '0;
			clr_ptr_q      <= '0;
			ptr_q          <= '0;
			bwr_v_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			count_q        <= count_d;
			result_valid_q <= (cmd.exec && !(!err_q && op_logic)) || cmd.count || cmd.bulk_last;
			if (cmd.cfg_load) begin
				cfg_bits_q <= cfg_data;
				clr_ptr_q  <= '0;
				bwr_v_q    <= 1'b0;
			end else if (cmd.clr_step) begin
				clr_ptr_q <= clr_ptr_q + AW'(1);
			end
			if (cmd.accept) begin
				ptr_q   <= '0;
				bwr_v_q <= 1'b0;
			end else if (cmd.bulk_step) begin
				if (ptr_q != nwords) begin
					ptr_q   <= ptr_q + 6'd1;
					bwr_v_q <= 1'b1;
				end else begin
					bwr_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode;
			bit_q  <= bit_pos[5:0];
			widx_q <= acc_widx;
			src_q  <= source_word;
			err_q  <= in_err;
		end
		if (cmd.bulk_step) begin
			bwr_w_q <= ptr_q;
		end
		if (cmd.exec) begin
			old_s1        <= old_word;
			new_s1        <= new_word;
			status_q      <= err_q;
			bit_value_q   <= ex_bitv;
			words_equal_q <= ex_eq;
		end else if (cmd.bulk_last) begin
			status_q      <= 1'b0;
			bit_value_q   <= 1'b0;
			words_equal_q <= 1'b0;
		end
	end

	assign sts.in_bulk    = in_bulk;
	assign sts.need_count = !err_q && op_logic;
	assign sts.bulk_done  = (ptr_q == nwords);
	assign sts.clr_done   = (clr_ptr_q == AW'(STORE_WORDS - 1));

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign bit_value    = bit_value_q;
	assign words_equal  = words_equal_q;
	assign set_count    = count_q;
	assign all_set      = (count_q == nbits);
	assign any_set      = (count_q != '0);
	assign none_set     = (count_q == '0);

	`BVS_ASSERT(a_count_bound, count_q <= nbits, "set count above bits in use")
	`BVS_ASSERT_NEXT(a_strobe_gap, result_valid_q, !result_valid_q, "results on adjacent cycles")
	`BVS_ASSERT(a_walk_write, !bwr_v_q || cmd.bulk_step || cmd.cfg_load, "walk write outside walk")

endmodule
